[sv/lrrb_pkg.sv]
`default_nettype none

package lrrb_pkg;

	// Ring geometry and line limits.
	localparam int RING_DEPTH = 256;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int MAX_LINE   = 64;
	localparam int CNT_W      = $clog2(MAX_LINE);
	localparam int CAP_W      = 7;

	// Line ending characters.
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// Item kinds on the input tuser.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Result status codes on the output tuser.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT_RD,
		S_EMIT_WAIT,
		S_FINISH,
		S_SKIP_RD,
		S_SKIP_CHK
	} state_t;

	// Next position around the ring.
	function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	// True for CR or LF.
	function automatic logic is_eol(input logic [7:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

endpackage

`default_nettype wire

[sv/lrrb_ram.sv]
`default_nettype none

// Generic memory: one write port, one read port, registered read data.
module lrrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

[sv/line_receive_ring_buffer.sv]
// Channel | Direction | tdata                                  | tuser        | tlast
// s_*     | in        | [7:0] rx_byte, [14:8] line_capacity    | cmd          | burst_end
// m_*     | out       | [7:0] char_out, [39:8] overflow_count  | status       | is_end
//
// A push leaves the controller in S_IDLE, so input is accepted again in the next cycle.
// A read first scans the ring at one entry per cycle through the registered
// memory read. It then passes each line byte through S_EMIT_RD and S_EMIT_WAIT
// and each skipped CR/LF through S_SKIP_RD and S_SKIP_CHK, bound by the single
// read port of the ring memory; input waits meanwhile.
// Reset clears the pointers, the overflow counter and the drop flag; the ring
// memory itself is not cleared. A stalled output holds the controller.
`default_nettype none

module line_receive_ring_buffer
	import lrrb_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [7:0] rx_byte, [14:8] line_capacity, [15] zero
	input  wire         s_tuser,   // [0] cmd
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [7:0] char_out, [39:8] overflow_count
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	state_t state_q, state_nx;

	logic [PTR_W-1:0] head_q, tail_q, cur_q, eol_q, addr_s1;
	logic             pend_s1;
	logic [CNT_W-1:0] k_q, lim_q;
	logic [1:0]       res_q;
	logic [31:0]      ovf_q;
	logic             drop_q;

	logic             ov_q;
	logic [7:0]       och_q;
	logic [1:0]       ost_q;
	logic             oend_q;
	logic [31:0]      ocnt_q;

	logic             ram_we;
	logic [PTR_W-1:0] ram_rd_addr;
	logic [7:0]       ram_rd_data;

	logic             in_acc;
	logic             out_free;
	logic             hit;
	logic [7:0]       rx_byte;
	logic [CAP_W-1:0] line_cap;
	logic             full;

	assign rx_byte  = s_tdata[7:0];
	assign line_cap = s_tdata[14:8];
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !ov_q || m_tready;
	assign hit      = pend_s1 && is_eol(ram_rd_data);
	assign full     = (ring_advance(head_q) == tail_q);

	lrrb_ram #(
		.WIDTH(8),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(head_q),
		.wr_data(rx_byte),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && s_tuser == CMD_READ) begin
					state_nx = (line_cap == '0) ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_nx = S_EMIT_RD;
				end else if (cur_q == head_q) begin
					state_nx = S_FINISH;
				end
			end
			S_EMIT_RD: begin
				state_nx = (tail_q != eol_q && k_q != lim_q) ? S_EMIT_WAIT : S_FINISH;
			end
			S_EMIT_WAIT: begin
				if (out_free) begin
					state_nx = S_EMIT_RD;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_nx = (res_q == ST_OK) ? S_SKIP_RD : S_IDLE;
				end
			end
			S_SKIP_RD: begin
				state_nx = (tail_q == head_q) ? S_IDLE : S_SKIP_CHK;
			end
			S_SKIP_CHK: begin
				state_nx = is_eol(ram_rd_data) ? S_SKIP_RD : S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		ram_we      = 1'b0;
		ram_rd_addr = tail_q;
		unique case (state_q)
			S_IDLE: begin
				ram_we = in_acc && s_tuser == CMD_PUSH && !drop_q && !full;
			end
			S_SCAN: begin
				ram_rd_addr = cur_q;
			end
			default: begin
				ram_rd_addr = tail_q;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Pointers, overflow tracking and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			ovf_q   <= '0;
			drop_q  <= 1'b0;
			pend_s1 <= 1'b0;
			res_q   <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && s_tuser == CMD_PUSH) begin
						if (drop_q) begin
							if (s_tlast) begin
								drop_q <= 1'b0;
							end
						end else if (full) begin
							ovf_q <= ovf_q + 32'd1;
							if (!s_tlast) begin
								drop_q <= 1'b1;
							end
						end else begin
							head_q <= ring_advance(head_q);
						end
					end else if (in_acc) begin
						pend_s1 <= 1'b0;
						res_q   <= (line_cap == '0) ? ST_INVALID : ST_OK;
					end
				end
				S_SCAN: begin
					if (hit) begin
						pend_s1 <= 1'b0;
					end else if (cur_q == head_q) begin
						res_q <= ST_BUSY;
					end else begin
						pend_s1 <= 1'b1;
					end
				end
				S_EMIT_WAIT: begin
					if (out_free) begin
						tail_q <= ring_advance(tail_q);
					end
				end
				S_SKIP_CHK: begin
					if (is_eol(ram_rd_data)) begin
						tail_q <= ring_advance(tail_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Scan cursor, line end position and byte count.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q <= tail_q;
				if (line_cap > CAP_W'(MAX_LINE)) begin
					lim_q <= CNT_W'(MAX_LINE - 1);
				end else begin
					lim_q <= CNT_W'(line_cap - CAP_W'(1));
				end
			end
			S_SCAN: begin
				if (hit) begin
					eol_q <= addr_s1;
					k_q   <= '0;
				end else begin
					addr_s1 <= cur_q;
					cur_q   <= ring_advance(cur_q);
				end
			end
			S_EMIT_WAIT: begin
				if (out_free) begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if ((state_q == S_EMIT_WAIT || state_q == S_FINISH) && out_free) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_EMIT_WAIT) begin
				och_q  <= ram_rd_data;
				ost_q  <= ST_OK;
				oend_q <= 1'b0;
			end else if (state_q == S_FINISH) begin
				och_q  <= 8'd0;
				ost_q  <= res_q;
				oend_q <= 1'b1;
			end
		end
	end

	// The overflow total cannot move while a read is in progress.
	always_ff @(posedge clk) begin
		if (out_free && (state_q == S_EMIT_WAIT || state_q == S_FINISH)) begin
			ocnt_q <= ovf_q;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {ocnt_q, och_q};
	assign m_tuser  = ost_q;
	assign m_tlast  = oend_q;

endmodule

`default_nettype wire

[test/lrrb_line_checker.sv]
module lrrb_line_checker
	import lrrb_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [15:0] s_tdata,   // [7:0] rx_byte, [14:8] line_capacity, [15] zero
	input  wire        s_tuser,   // [0] cmd
	input  wire        s_tlast,
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [39:0] m_tdata,   // [7:0] char_out, [39:8] overflow_count
	input  wire [1:0]  m_tuser,   // [1:0] status
	input  wire        m_tlast,
	output int         error_count,
	output int         pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  ch;
		logic [1:0]  status;
		logic        is_end;
		logic [31:0] drops;
	} line_result_t;

	// Shadow copy of the ring. The pointers are PTR_W bits wide, so they wrap
	// around the ring by themselves.
	logic [7:0]       ring_mem [RING_DEPTH];
	logic [PTR_W-1:0] wr_ptr;
	logic [PTR_W-1:0] rd_ptr;
	logic [31:0]      drop_bursts;
	logic             drop_active;
	line_result_t     line_results_q[$];

	initial begin
		error_count   = 0;
		pending_count = 0;
	end

	function automatic logic ends_line(input logic [7:0] c);
		return (c == CH_LF) || (c == CH_CR);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		error_count++;
	endtask

	task automatic queue_result(input logic [7:0] ch, input logic [1:0] status,
			input logic is_end);
		line_results_q.push_back('{ch, status, is_end, drop_bursts});
	endtask

	// Works out the effect of one accepted item and queues the lines it yields.
	task automatic model_item(input logic cmd, input logic [7:0] data, input logic last,
			input logic [CAP_W-1:0] cap);
		logic [PTR_W-1:0] scan;
		logic [PTR_W-1:0] nxt;
		int               room;
		int               k;
		if (cmd == CMD_PUSH) begin
			if (drop_active) begin
				// Rest of a cut burst: discard until its last byte.
				if (last) begin
					drop_active = 1'b0;
				end
			end else begin
				nxt = wr_ptr + 1'b1;
				if (nxt == rd_ptr) begin
					// Full ring: count the burst once and drop what remains of it.
					drop_bursts = drop_bursts + 1;
					if (!last) begin
						drop_active = 1'b1;
					end
				end else begin
					ring_mem[wr_ptr] = data;
					wr_ptr = nxt;
				end
			end
		end else if (cap == '0) begin
			queue_result(8'h00, ST_INVALID, 1'b1);
		end else begin
			room = (cap > MAX_LINE) ? MAX_LINE - 1 : int'(cap) - 1;
			scan = rd_ptr;
			while (scan != wr_ptr && !ends_line(ring_mem[scan])) begin
				scan = scan + 1'b1;
			end
			if (scan == wr_ptr) begin
				// No complete line yet; nothing is consumed.
				queue_result(8'h00, ST_BUSY, 1'b1);
			end else begin
				k = 0;
				while (rd_ptr != scan && k < room) begin
					queue_result(ring_mem[rd_ptr], ST_OK, 1'b0);
					rd_ptr = rd_ptr + 1'b1;
					k++;
				end
				queue_result(8'h00, ST_OK, 1'b1);
				// Swallow the CR/LF run after the line; a cut line leaves none here.
				while (rd_ptr != wr_ptr && ends_line(ring_mem[rd_ptr])) begin
					rd_ptr = rd_ptr + 1'b1;
				end
			end
		end
	endtask

	// Compares one output item with the oldest expected line byte or status.
	task automatic check_result();
		line_result_t want;
		if (line_results_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result char %h status %0d end %b",
				m_tdata[7:0], m_tuser, m_tlast));
		end else begin
			want = line_results_q.pop_front();
			if (m_tdata[7:0] !== want.ch) begin
				report_mismatch($sformatf("char_out %h, expected %h", m_tdata[7:0], want.ch));
			end
			if (m_tuser !== want.status) begin
				report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
			end
			if (m_tlast !== want.is_end) begin
				report_mismatch($sformatf("is_end %b, expected %b", m_tlast, want.is_end));
			end
			if (m_tdata[39:8] !== want.drops) begin
				report_mismatch($sformatf("overflow_count %0d, expected %0d",
					m_tdata[39:8], want.drops));
			end
		end
	endtask

	// Outputs are checked before the input of the same edge is modeled, since a
	// result on the bus can never stem from an item accepted at that very edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr      = '0;
			rd_ptr      = '0;
			drop_bursts = '0;
			drop_active = 1'b0;
			line_results_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (s_tvalid && s_tready) begin
				model_item(s_tuser, s_tdata[7:0], s_tlast, s_tdata[14:8]);
			end
		end
		pending_count = line_results_q.size();
	end

endmodule

[test/tb_line_receive_ring_buffer.sv]
module tb_line_receive_ring_buffer
	import lrrb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // [7:0] rx_byte, [14:8] line_capacity, [15] zero
	logic        s_tuser  = 1'b0;  // [0] cmd
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // [7:0] char_out, [39:8] overflow_count
	logic [1:0]  m_tuser;          // [1:0] status
	logic        m_tlast;

	int error_count;
	int pending_count;
	int items_sent = 0;
	int idle_pct   = 0;
	int stall_pct  = 0;

	line_receive_ring_buffer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lrrb_line_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Output back-pressure at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Offers one item after a random idle gap and holds it until accepted.
	task automatic send_item(input logic cmd, input logic [7:0] data, input logic last,
			input logic [CAP_W-1:0] cap);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tlast  <= last;
		s_tdata  <= {1'b0, cap, data};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Read request; the byte and marker fields are don't-care and get noise.
	task automatic read_line(input logic [CAP_W-1:0] cap);
		send_item(CMD_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), cap);
	endtask

	// One burst of text closed by the given line ending.
	task automatic push_line(input string txt, input logic [7:0] term);
		for (int i = 0; i < txt.len(); i++) begin
			send_item(CMD_PUSH, txt[i], 1'b0, CAP_W'($urandom_range(127)));
		end
		send_item(CMD_PUSH, term, 1'b1, CAP_W'($urandom_range(127)));
	endtask

	// Random burst; each byte is a CR or LF with the given chance.
	task automatic push_burst(input int len, input int eol_pct);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < eol_pct) begin
				b = $urandom_range(1) ? CH_CR : CH_LF;
			end else begin
				b = 8'($urandom_range(255));
			end
			send_item(CMD_PUSH, b, i == len - 1, CAP_W'($urandom_range(127)));
		end
	endtask

	function automatic logic [CAP_W-1:0] pick_capacity();
		int r;
		r = $urandom_range(99);
		if (r < 5) begin
			return '0;
		end
		if (r < 15) begin
			return CAP_W'($urandom_range(127, MAX_LINE + 1));
		end
		if (r < 35) begin
			return CAP_W'($urandom_range(4, 1));
		end
		return CAP_W'($urandom_range(MAX_LINE, 5));
	endfunction

	// Mostly well-formed traffic: bursts and reads, with some stray items.
	task automatic run_mix(input int count);
		int target;
		int r;
		target = items_sent + count;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 55) begin
				push_burst($urandom_range(16, 1), 12);
			end else if (r < 90) begin
				read_line(pick_capacity());
			end else begin
				send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)), CAP_W'($urandom_range(127)));
			end
		end
	endtask

	initial begin
		int target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty ring, short lines, CR/LF runs, cut lines, byte extremes.
		read_line('0);
		read_line(CAP_W'(10));
		push_line("AB", CH_CR);
		send_item(CMD_PUSH, CH_LF, 1'b1, '0);
		read_line(CAP_W'(MAX_LINE));
		push_line("HELLO", CH_LF);
		read_line(CAP_W'(3));
		read_line(CAP_W'(1));
		read_line(CAP_W'(127));
		send_item(CMD_PUSH, 8'hFF, 1'b0, CAP_W'(127));
		send_item(CMD_PUSH, 8'h00, 1'b0, '0);
		send_item(CMD_PUSH, CH_LF, 1'b1, CAP_W'(64));
		read_line(CAP_W'(2));
		read_line(CAP_W'(MAX_LINE));
		send_item(CMD_PUSH, CH_CR, 1'b1, '0);
		read_line(CAP_W'(MAX_LINE));
		read_line(CAP_W'(MAX_LINE));
		send_item(CMD_PUSH, 8'h58, 1'b1, '0);
		read_line(CAP_W'(5));

		// Random traffic with no idling.
		run_mix(16);

		// Sender idles often.
		idle_pct = 46;
		run_mix(16);

		// Receiver stalls often; flood the ring past full so bursts get cut,
		// then drain it by lines.
		idle_pct  = 0;
		stall_pct = 46;
		target = items_sent + 260;
		while (items_sent < target) begin
			push_burst($urandom_range(40, 1), 6);
		end
		repeat (20) read_line(CAP_W'($urandom_range(127, 40)));
		run_mix(16);

		// Both sides idle now and then.
		idle_pct  = 13;
		stall_pct = 13;
		run_mix(16);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		// A read may still be skipping a long CR/LF run after its last result.
		repeat (700) @(posedge clk);
		if (error_count == 0 && pending_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
